[hw/rtl/gda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Shared types, status codes, calendar tables and reciprocal constants.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int IN_W   = 72;
    localparam int OUT_W  = 48;
    localparam int SER_W  = 25;   // day numbers up to the top of year 65535
    localparam int CNT_W  = 23;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_RANGE    = 2'd2
    } gda_status_t;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_DIFF = 1'b1
    } gda_op_t;

    // Sideband that travels with each item through the conversion pipeline.
    typedef struct packed {
        gda_op_t                 op;
        gda_status_t             status;
        logic signed [CNT_W-1:0] cnt;
    } gda_side_t;

    // Reciprocals: floor(x / d) == (x * K) >> S for every x below 2**N,
    // with S = N + ceil(log2 d) and K = ceil(2**S / d).
    localparam int R100_S = 21;    // 14-bit operands
    localparam longint unsigned R100_KL = ((64'd1 << R100_S) + 64'd99) / 64'd100;
    localparam logic [14:0] R100_K = 15'(R100_KL);

    localparam int R400Y_S = 43;   // 25-bit operands, divisor 146097
    localparam longint unsigned R400Y_KL = ((64'd1 << R400Y_S) + 64'd146096) / 64'd146097;
    localparam logic [25:0] R400Y_K = 26'(R400Y_KL);

    localparam int R100Y_S = 34;   // 18-bit operands, divisor 36524
    localparam longint unsigned R100Y_KL = ((64'd1 << R100Y_S) + 64'd36523) / 64'd36524;
    localparam logic [18:0] R100Y_K = 19'(R100Y_KL);

    localparam int R4Y_S = 27;     // 16-bit operands, divisor 1461
    localparam longint unsigned R4Y_KL = ((64'd1 << R4Y_S) + 64'd1460) / 64'd1461;
    localparam logic [16:0] R4Y_K = 17'(R4Y_KL);

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] st;
        unique case (m)
            4'd1:    st = 9'd0;
            4'd2:    st = 9'd31;
            4'd3:    st = 9'd59;
            4'd4:    st = 9'd90;
            4'd5:    st = 9'd120;
            4'd6:    st = 9'd151;
            4'd7:    st = 9'd181;
            4'd8:    st = 9'd212;
            4'd9:    st = 9'd243;
            4'd10:   st = 9'd273;
            4'd11:   st = 9'd304;
            4'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

endpackage

[hw/rtl/gregorian_date_arithmetic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic
// Adds a day offset to a date, or subtracts two dates, in the proleptic
// Gregorian calendar with day 1 on 01/01/0001.
// ----------------------------------------------------------------------------
// Each input item carries an opcode on s_axis_tuser and its operands on
// s_axis_tdata; each yields exactly one result item on m_axis, in order, with
// the status on m_axis_tuser. Opcode 0 returns the date A plus offset_days,
// opcode 1 returns A minus B in days. Invalid input dates give status 1; a
// result outside years 1 to MAX_YEAR, or a difference that overflows the
// 23-bit signed count, gives status 2, with every other result field zero.
// The path is eleven register stages: three that turn dates into day numbers
// and add or subtract, and eight that turn a day number back into a date.
// One item is accepted every cycle while s_axis_tready is high. Each stage
// holds its own valid bit, so a stall on m_axis_tready fills empty stages
// before s_axis_tready drops, and nothing is lost or repeated. Reset clears
// all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic
#(
    parameter int MAX_YEAR = 9999
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // day_a, month_a, year_a, day_b, month_b, year_b, offset_days
    input  logic [gda_pkg::IN_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // res_day, res_month, res_year, day_count
    output logic [gda_pkg::OUT_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]                m_axis_tuser
);
    import gda_pkg::*;

    localparam longint TOP_DAY = 365 * longint'(MAX_YEAR) + longint'(MAX_YEAR) / 4
                                 - longint'(MAX_YEAR) / 100 + longint'(MAX_YEAR) / 400;
    localparam logic [16:0] MAX_Y = 17'(MAX_YEAR);

    logic [2:0] v_reg;
    logic [2:0] en;
    logic       sub_ready;
    logic [OUT_W-1:0] ymd_data;

    // Input fields
    logic        in_op;
    logic [4:0]  in_da, in_db;
    logic [3:0]  in_ma, in_mb;
    logic [13:0] in_ya, in_yb;
    logic signed [22:0] in_off;

    assign in_op  = s_axis_tuser;
    assign in_da  = s_axis_tdata[4:0];
    assign in_ma  = s_axis_tdata[8:5];
    assign in_ya  = s_axis_tdata[22:9];
    assign in_db  = s_axis_tdata[27:23];
    assign in_mb  = s_axis_tdata[31:28];
    assign in_yb  = s_axis_tdata[45:32];
    assign in_off = s_axis_tdata[68:46];

    // Stage 1: century quotients
    logic        s1_op_reg;
    logic [4:0]  s1_da_reg, s1_db_reg;
    logic [3:0]  s1_ma_reg, s1_mb_reg;
    logic [13:0] s1_ya_reg, s1_yb_reg;
    logic signed [22:0] s1_off_reg;
    logic [7:0]  s1_pqa_reg, s1_pqb_reg, s1_yqa_reg, s1_yqb_reg;

    logic [13:0] pa, pb;
    logic [28:0] mpa, mpb, mya, myb;

    // Stage 2: day numbers and validity
    logic        s2_op_reg;
    logic        s2_va_reg, s2_vb_reg;
    logic [23:0] s2_sa_reg, s2_sb_reg;
    logic signed [22:0] s2_off_reg;

    logic        leap_a, leap_b, va_next, vb_next;
    logic [4:0]  len_a, len_b;
    logic [13:0] p2a, p2b;
    logic [23:0] sa_next, sb_next;

    // Stage 3: sum or difference and range checks
    logic [SER_W-1:0] s3_n_reg;
    gda_side_t        s3_side_reg;

    logic signed [25:0] sum_s, diff_s;
    gda_side_t          side_next;
    logic [SER_W-1:0]   n_next;

    always_comb
    begin
        en[2] = !v_reg[2] || sub_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= s_axis_tvalid;
            if (en[1])
                v_reg[1] <= v_reg[0];
            if (en[2])
                v_reg[2] <= v_reg[1];
        end
    end

    always_comb
    begin
        pa  = in_ya - 14'd1;
        pb  = in_yb - 14'd1;
        mpa = 29'(pa) * 29'(R100_K);
        mpb = 29'(pb) * 29'(R100_K);
        mya = 29'(in_ya) * 29'(R100_K);
        myb = 29'(in_yb) * 29'(R100_K);
    end

    always_comb
    begin
        p2a = s1_ya_reg - 14'd1;
        p2b = s1_yb_reg - 14'd1;
        leap_a = (s1_ya_reg[1:0] == 2'd0)
                 && ((s1_ya_reg != 14'(15'(s1_yqa_reg) * 15'd100)) || (s1_yqa_reg[1:0] == 2'd0));
        leap_b = (s1_yb_reg[1:0] == 2'd0)
                 && ((s1_yb_reg != 14'(15'(s1_yqb_reg) * 15'd100)) || (s1_yqb_reg[1:0] == 2'd0));
        len_a = (s1_ma_reg == 4'd2 && leap_a) ? 5'd29 : month_len(s1_ma_reg);
        len_b = (s1_mb_reg == 4'd2 && leap_b) ? 5'd29 : month_len(s1_mb_reg);
        va_next = (s1_ya_reg != 14'd0) && (17'(s1_ya_reg) <= MAX_Y)
                  && (s1_ma_reg >= 4'd1) && (s1_ma_reg <= 4'd12)
                  && (s1_da_reg != 5'd0) && (s1_da_reg <= len_a);
        vb_next = (s1_yb_reg != 14'd0) && (17'(s1_yb_reg) <= MAX_Y)
                  && (s1_mb_reg >= 4'd1) && (s1_mb_reg <= 4'd12)
                  && (s1_db_reg != 5'd0) && (s1_db_reg <= len_b);
        sa_next = 24'(p2a) * 24'd365 + 24'(p2a[13:2]) - 24'(s1_pqa_reg) + 24'(s1_pqa_reg[7:2])
                  + 24'(month_start(s1_ma_reg)) + 24'(s1_da_reg)
                  + 24'((s1_ma_reg > 4'd2) && leap_a);
        sb_next = 24'(p2b) * 24'd365 + 24'(p2b[13:2]) - 24'(s1_pqb_reg) + 24'(s1_pqb_reg[7:2])
                  + 24'(month_start(s1_mb_reg)) + 24'(s1_db_reg)
                  + 24'((s1_mb_reg > 4'd2) && leap_b);
    end

    always_comb
    begin
        sum_s  = $signed({2'b00, s2_sa_reg}) + 26'(s2_off_reg);
        diff_s = $signed({2'b00, s2_sa_reg}) - $signed({2'b00, s2_sb_reg});
        n_next = SER_W'(sum_s - 26'sd1);
        side_next.op     = gda_op_t'(s2_op_reg);
        side_next.status = ST_OK;
        side_next.cnt    = '0;
        if (s2_op_reg == OP_ADD)
        begin
            if (!s2_va_reg)
                side_next.status = ST_INVALID;
            else if (sum_s < 26'sd1 || sum_s > $signed(26'(TOP_DAY)))
                side_next.status = ST_RANGE;
        end
        else
        begin
            if (!(s2_va_reg && s2_vb_reg))
                side_next.status = ST_INVALID;
            else if (diff_s < -26'sd4194304 || diff_s > 26'sd4194303)
                side_next.status = ST_RANGE;
            else
                side_next.cnt = diff_s[22:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_op_reg  <= in_op;
            s1_da_reg  <= in_da;
            s1_ma_reg  <= in_ma;
            s1_ya_reg  <= in_ya;
            s1_db_reg  <= in_db;
            s1_mb_reg  <= in_mb;
            s1_yb_reg  <= in_yb;
            s1_off_reg <= in_off;
            s1_pqa_reg <= mpa[R100_S +: 8];
            s1_pqb_reg <= mpb[R100_S +: 8];
            s1_yqa_reg <= mya[R100_S +: 8];
            s1_yqb_reg <= myb[R100_S +: 8];
        end
        if (en[1])
        begin
            s2_op_reg  <= s1_op_reg;
            s2_va_reg  <= va_next;
            s2_vb_reg  <= vb_next;
            s2_sa_reg  <= sa_next;
            s2_sb_reg  <= sb_next;
            s2_off_reg <= s1_off_reg;
        end
        if (en[2])
        begin
            s3_n_reg    <= n_next;
            s3_side_reg <= side_next;
        end
    end

    gda_to_ymd u_to_ymd
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[2]),
        .in_ready  (sub_ready),
        .in_day    (s3_n_reg),
        .in_side   (s3_side_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (ymd_data)
    );

    // The converter carries the status in its top two bits; it leaves on tuser.
    assign m_axis_tdata = {2'b00, ymd_data[45:0]};
    assign m_axis_tuser = ymd_data[47:46];

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("fields not cleared on error status");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK && m_axis_tdata[8:5] != 4'd0)
        |-> (m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] <= 4'd12))
        else $error("result date malformed");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule

[hw/rtl/gda_to_ymd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to date converter
// Eight-stage pipeline splitting a day number into 400, 100, 4 and 1 year
// cycles, then month and day, and forming the packed result item.
// ----------------------------------------------------------------------------
module gda_to_ymd
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [gda_pkg::SER_W-1:0] in_day,     // day number minus one
    input  gda_pkg::gda_side_t       in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [gda_pkg::OUT_W-1:0] out_data
);
    import gda_pkg::*;

    localparam int NS = 8;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    gda_side_t side_reg [NS-1];

    logic [SER_W-1:0] n0_reg;
    logic [7:0]       q400_reg [6];
    logic [17:0]      r1_reg, r2_reg;
    logic [1:0]       q100_reg [4];
    logic [15:0]      r3_reg, r4_reg;
    logic [4:0]       q4_reg [2];
    logic [10:0]      r5_reg;
    logic [8:0]       doy_reg;
    logic [15:0]      year_reg;
    logic             leap_reg;
    logic [OUT_W-1:0] out_reg;

    logic [50:0] p400;
    logic [36:0] p100;
    logic [32:0] p4;
    logic [7:0]  q400_next;
    logic [17:0] r1_next;
    logic [2:0]  q100_raw;
    logic [1:0]  q100_next;
    logic [15:0] r3_next;
    logic [4:0]  q4_next;
    logic [10:0] r5_next;
    logic [1:0]  q1;
    logic [8:0]  doy_next;
    logic [15:0] year_next;
    logic        leap_next;
    logic [3:0]  mo;
    logic [8:0]  mo_start;
    logic [4:0]  day;
    logic [OUT_W-1:0] out_next;
    logic             ok;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage arithmetic
    always_comb
    begin
        p400      = 51'(in_day) * 51'(R400Y_K);
        q400_next = p400[R400Y_S +: 8];

        r1_next   = 18'(n0_reg - 25'(26'(q400_reg[0]) * 26'd146097));

        p100      = 37'(r1_reg) * 37'(R100Y_K);
        q100_raw  = p100[R100Y_S +: 3];
        q100_next = (q100_raw > 3'd3) ? 2'd3 : q100_raw[1:0];

        r3_next   = 16'(r2_reg - 18'(18'(q100_reg[0]) * 18'd36524));

        p4        = 33'(r3_reg) * 33'(R4Y_K);
        q4_next   = p4[R4Y_S +: 5];

        r5_next   = 11'(r4_reg - 16'(16'(q4_reg[0]) * 16'd1461));

        if (r5_reg >= 11'd1095)
            q1 = 2'd3;
        else if (r5_reg >= 11'd730)
            q1 = 2'd2;
        else if (r5_reg >= 11'd365)
            q1 = 2'd1;
        else
            q1 = 2'd0;
        doy_next  = 9'(r5_reg - 11'(11'(q1) * 11'd365));
        year_next = 16'(17'(q400_reg[5]) * 17'd400 + 17'(q100_reg[3]) * 17'd100
                        + 17'(q4_reg[1]) * 17'd4 + 17'(q1) + 17'd1);
        // The last year of each four-year cycle is leap, except at a century
        // boundary that is not also a 400-year boundary.
        leap_next = (q1 == 2'd3) && ((q4_reg[1] != 5'd24) || (q100_reg[3] == 2'd3));
    end

    // Month search over the twelve month starts, then the output item.
    always_comb
    begin
        mo = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (doy_reg >= 9'(month_start(4'(k)) + ((k > 2) ? 9'(leap_reg) : 9'd0)))
            begin
                mo = 4'(k);
            end
        end
        mo_start = month_start(mo) + ((mo > 4'd2) ? 9'(leap_reg) : 9'd0);
        day      = 5'(doy_reg - mo_start + 9'd1);
        ok       = (side_reg[NS-2].status == ST_OK);
        out_next = '0;
        out_next[47:46] = side_reg[NS-2].status;
        if (ok && side_reg[NS-2].op == OP_ADD)
        begin
            out_next[4:0]  = day;
            out_next[8:5]  = mo;
            out_next[22:9] = year_reg[13:0];
        end
        if (ok && side_reg[NS-2].op == OP_DIFF)
        begin
            out_next[45:23] = side_reg[NS-2].cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n0_reg      <= in_day;
            q400_reg[0] <= q400_next;
            side_reg[0] <= in_side;
        end
        if (en[1])
        begin
            r1_reg      <= r1_next;
            q400_reg[1] <= q400_reg[0];
            side_reg[1] <= side_reg[0];
        end
        if (en[2])
        begin
            r2_reg      <= r1_reg;
            q100_reg[0] <= q100_next;
            q400_reg[2] <= q400_reg[1];
            side_reg[2] <= side_reg[1];
        end
        if (en[3])
        begin
            r3_reg      <= r3_next;
            q100_reg[1] <= q100_reg[0];
            q400_reg[3] <= q400_reg[2];
            side_reg[3] <= side_reg[2];
        end
        if (en[4])
        begin
            r4_reg      <= r3_reg;
            q4_reg[0]   <= q4_next;
            q100_reg[2] <= q100_reg[1];
            q400_reg[4] <= q400_reg[3];
            side_reg[4] <= side_reg[3];
        end
        if (en[5])
        begin
            r5_reg      <= r5_next;
            q4_reg[1]   <= q4_reg[0];
            q100_reg[3] <= q100_reg[2];
            q400_reg[5] <= q400_reg[4];
            side_reg[5] <= side_reg[4];
        end
        if (en[6])
        begin
            doy_reg     <= doy_next;
            year_reg    <= year_next;
            leap_reg    <= leap_next;
            side_reg[6] <= side_reg[5];
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule

[test/tb_gregorian_date_arithmetic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic testbench
// Drives date-plus-offset and date-difference items with random gaps and
// stalls, predicts every result from a day-number model of the calendar and
// compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module tb_gregorian_date_arithmetic;
    import gda_pkg::*;

    localparam int MAX_YEAR  = 9999;
    localparam int LATENCY   = 11;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [22:0] count;
        gda_status_t        status;
    } date_result_t;

    typedef struct packed {
        logic            op;
        logic [IN_W-1:0] data;
    } date_item_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0]       m_axis_tuser;

    date_result_t pending_results[$];
    int           errors;
    int           cycles;
    bit           hold_off_req;
    bit           stall_enable;

    gregorian_date_arithmetic #(.MAX_YEAR(MAX_YEAR)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit leap_year(longint y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic longint days_in_month(longint m, longint y);
        longint len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_ok(longint d, longint m, longint y);
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1)
            return 0;
        return d <= days_in_month(m, y);
    endfunction

    function automatic longint year_base(longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic longint day_number(longint d, longint m, longint y);
        longint s;
        s = year_base(y) + d;
        for (longint k = 1; k < m; k++)
            s += days_in_month(k, y);
        return s;
    endfunction

    // Walks years by their base day number; a binary search keeps it quick.
    function automatic date_result_t date_of_day(longint s);
        date_result_t r;
        longint lo, hi, mid, y, m, rem;
        lo = 1;
        hi = MAX_YEAR;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (year_base(mid) < s) lo = mid;
            else hi = mid - 1;
        end
        y = lo;
        rem = s - year_base(y);
        m = 1;
        while (rem > days_in_month(m, y))
        begin
            rem -= days_in_month(m, y);
            m++;
        end
        r = '0;
        r.day = 5'(rem);
        r.month = 4'(m);
        r.year = 14'(y);
        return r;
    endfunction

    function automatic date_result_t predict_date_op(date_item_t it);
        date_result_t r;
        longint da, ma, ya, db, mb, yb, off, s, diff;
        r = '0;
        da = longint'(it.data[4:0]);   ma = longint'(it.data[8:5]);
        ya = longint'(it.data[22:9]);
        db = longint'(it.data[27:23]); mb = longint'(it.data[31:28]);
        yb = longint'(it.data[45:32]);
        off = longint'($signed(it.data[68:46]));
        if (it.op == OP_ADD)
        begin
            if (!date_ok(da, ma, ya))
                r.status = ST_INVALID;
            else
            begin
                s = day_number(da, ma, ya) + off;
                if (s < 1 || s > year_base(MAX_YEAR + 1))
                    r.status = ST_RANGE;
                else
                    r = date_of_day(s);
            end
        end
        else
        begin
            if (!date_ok(da, ma, ya) || !date_ok(db, mb, yb))
                r.status = ST_INVALID;
            else
            begin
                diff = day_number(da, ma, ya) - day_number(db, mb, yb);
                if (diff < -4194304 || diff > 4194303) r.status = ST_RANGE;
                else r.count = 23'(diff);
            end
        end
        return r;
    endfunction

    function automatic date_item_t pack_item(bit op, int da, int ma, int ya,
                                             int db, int mb, int yb, int off);
        date_item_t it;
        it = '0;
        it.op = op;
        it.data[4:0] = 5'(da);   it.data[8:5] = 4'(ma);   it.data[22:9] = 14'(ya);
        it.data[27:23] = 5'(db); it.data[31:28] = 4'(mb); it.data[45:32] = 14'(yb);
        it.data[68:46] = 23'(off);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(date_item_t it, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= it.op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_results.push_back(predict_date_op(it));
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic int rand_year();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(1, 3);
        if (r == 1) return $urandom_range(9997, 9999);
        if (r == 2) return $urandom_range(0, 16383);
        return $urandom_range(1, 9999);
    endfunction

    function automatic int rand_day();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
    endfunction

    function automatic int rand_month();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    endfunction

    function automatic int rand_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 2000) - 1000;
        if (r < 8) return $urandom_range(0, 7304118) - 3652059;
        return $urandom_range(0, 32'h7FFFFF) - 32'h400000;
    endfunction

    task automatic test_directed();
        send_item(pack_item(OP_ADD, 1, 1, 1, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 1, 1, 1, 0, 0, 0, -1), 0);
        send_item(pack_item(OP_ADD, 31, 12, 9999, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 31, 12, 9999, 0, 0, 0, 1), 0);
        send_item(pack_item(OP_ADD, 1, 1, 1, 0, 0, 0, 3652058), 0);
        send_item(pack_item(OP_ADD, 31, 12, 9999, 0, 0, 0, -3652058), 0);
        send_item(pack_item(OP_ADD, 28, 2, 2000, 0, 0, 0, 1), 0);
        send_item(pack_item(OP_ADD, 28, 2, 1900, 0, 0, 0, 1), 0);
        send_item(pack_item(OP_ADD, 29, 2, 1900, 0, 0, 0, 1), 0);
        send_item(pack_item(OP_ADD, 29, 2, 2024, 0, 0, 0, 365), 0);
        send_item(pack_item(OP_ADD, 0, 5, 100, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 31, 4, 100, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 1, 13, 100, 31, 15, 16383, 0), 0);
        send_item(pack_item(OP_ADD, 1, 1, 0, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 1, 1, 10000, 0, 0, 0, 0), 0);
        send_item(pack_item(OP_ADD, 31, 15, 16383, 0, 0, 0, 32'h3FFFFF), 0);
        send_item(pack_item(OP_ADD, 1, 1, 5000, 0, 0, 0, -32'h400000), 0);
        send_item(pack_item(OP_DIFF, 31, 12, 9999, 1, 1, 1, 0), 0);
        send_item(pack_item(OP_DIFF, 1, 1, 1, 31, 12, 9999, 0), 0);
        send_item(pack_item(OP_DIFF, 1, 3, 2000, 28, 2, 2000, 0), 0);
        send_item(pack_item(OP_DIFF, 1, 3, 2000, 29, 2, 2001, 0), 0);
        send_item(pack_item(OP_DIFF, 29, 2, 2000, 1, 1, 0, 0), 0);
        send_item(pack_item(OP_DIFF, 15, 6, 1234, 15, 6, 1234, 0), 0);
        end_burst();
    endtask

    task automatic test_random(int count);
        int yr;
        repeat (count)
        begin
            yr = rand_year();
            send_item(pack_item($urandom_range(0, 1), rand_day(), rand_month(), yr,
                                rand_day(), rand_month(), rand_year(), rand_offset()), 1);
        end
        end_burst();
    endtask

    // The receiver holds off while items keep coming so the pipeline fills up.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (40)
            send_item(pack_item($urandom_range(0, 1), rand_day(), rand_month(), rand_year(),
                                rand_day(), rand_month(), rand_year(), rand_offset()), 0);
        end_burst();
    endtask

    task automatic test_streaming();
        stall_enable = 1'b0;
        repeat (100)
            send_item(pack_item($urandom_range(0, 1), rand_day(), rand_month(), rand_year(),
                                rand_day(), rand_month(), rand_year(), rand_offset()), 0);
        end_burst();
        stall_enable = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold = 0;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold = 60;
            m_axis_tready <= 1'b0;
        end
        else if (hold > 0)
        begin
            hold--;
            m_axis_tready <= 1'b0;
        end
        else if (!stall_enable)
            m_axis_tready <= 1'b1;
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) m_axis_tready <= 1'b1;
            else if (r < 97) m_axis_tready <= 1'b0;
            else
            begin
                hold = $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        date_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.day    = m_axis_tdata[4:0];
            got.month  = m_axis_tdata[8:5];
            got.year   = m_axis_tdata[22:9];
            got.count  = m_axis_tdata[45:23];
            got.status = gda_status_t'(m_axis_tuser);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.day !== want.day)
                begin
                    $error("res_day expected %0d actual %0d", want.day, got.day);
                    errors++;
                end
                if (got.month !== want.month)
                begin
                    $error("res_month expected %0d actual %0d", want.month, got.month);
                    errors++;
                end
                if (got.year !== want.year)
                begin
                    $error("res_year expected %0d actual %0d", want.year, got.year);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $error("day_count expected %0d actual %0d", want.count, got.count);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off_req = 1'b0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_streaming();
        test_random(700);
        repeat (LATENCY * 3) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
